FILE: design/tdq_pkg.sv
package tdq_pkg;

  // request kinds on in_tuser
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_EXP  = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // result kinds on out_tuser
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // most fired items per expire request
  localparam int MAX_FIRED = 16;

  // field widths
  localparam int SLOT_W = 4;
  localparam int TV_W   = 48;
  localparam int IV_W   = 32;

  // channel widths
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  // one result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              earliest;
    logic [TV_W-1:0]   deadline;
    logic              empty;
    logic              last;
  } res_t;

endpackage

FILE: design/timer_deadline_queue_unit.sv
// delete: no scan; the status result is registered in the push state once the output register is free
// add: one scan of the entry memory, then the result push; a busy or out-of-range slot skips the scan
// expire with F fired timers: F + 2 scans (F + 1 once F reaches MAX_FIRED) plus one push per
//   result; one read port sets every scan at one entry per cycle
// one item at a time; the next item is taken once the last result is registered
// reset is synchronous: valid marks clear at once, entry memory is undefined until written
module timer_deadline_queue_unit #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // timer_slot [3:0], time_value [51:4], repeat_interval [83:52], zero fill [87:84]
  input  logic [tdq_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type [1:0]
  input  logic [tdq_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status_code [1:0], fired_slot [5:2], became_earliest [6], next_deadline [54:7],
  // queue_empty [55]
  output logic [tdq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // result_kind [1:0]
  output logic [tdq_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);

  import tdq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = $clog2(MAX_FIRED + 1);
  localparam int MW = TIME_BITS + IV_W;
  localparam int SW = ((TIME_BITS > IV_W) ? TIME_BITS : IV_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  // control state
  logic [2:0]          state_r, state_nxt;
  logic [2:0]          ret_r, ret_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] taken_r, taken_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                dv_r, dv_nxt;
  logic                found_r, found_nxt;
  logic [FW-1:0]       nfired_r, nfired_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [TIME_BITS-1:0] tv_r, tv_nxt;
  logic [IV_W-1:0]      iv_r, iv_nxt;
  logic [IW-1:0]        didx_r, didx_nxt;
  logic [TIME_BITS-1:0] best_r, best_nxt;
  logic [IW-1:0]        bidx_r, bidx_nxt;
  res_t                 pend_r, pend_nxt;
  res_t                 out_r, out_nxt;

  // entry memory
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [MW-1:0]        mem_wdata;
  logic [MW-1:0]        mem_rdata;
  logic [TIME_BITS-1:0] rd_dl;
  logic [IV_W-1:0]      rd_iv;

  // scan helpers
  logic                 scanning;
  logic                 scan_done;
  logic                 cand_ok;
  logic [TIME_BITS-1:0] cand_d;
  logic [SW-1:0]        upd_sum;
  logic [TIME_BITS-1:0] upd_dl;
  logic                 in_acc;
  logic                 slot_in_range;
  logic [IW-1:0]        in_idx;

  tdq_ram #(
    .WIDTH(MW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (mem_rdata)
  );

  assign rd_dl = mem_rdata[MW-1:IV_W];
  assign rd_iv = mem_rdata[IV_W-1:0];

  // saturating re-arm deadline
  assign upd_sum = SW'(tv_r) + SW'(rd_iv);
  assign upd_dl  = (|upd_sum[SW-1:TIME_BITS]) ? {TIME_BITS{1'b1}} : upd_sum[TIME_BITS-1:0];

  assign scanning  = (state_r == S_ADD) || (state_r == S_FIRE) || (state_r == S_UPD);
  assign scan_done = scanning && (cnt_r == CW'(CAPACITY)) && !dv_r;

  assign in_tready     = (state_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign slot_in_range = (32'(in_tdata[SLOT_W-1:0]) < CAPACITY);
  assign in_idx        = IW'(in_tdata[SLOT_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    valid_nxt     = valid_r;
    taken_nxt     = taken_r;
    cnt_nxt       = cnt_r;
    dv_nxt        = dv_r;
    found_nxt     = found_r;
    nfired_nxt    = nfired_r;
    out_valid_nxt = out_valid_r;
    slot_nxt      = slot_r;
    tv_nxt        = tv_r;
    iv_nxt        = iv_r;
    didx_nxt      = didx_r;
    best_nxt      = best_r;
    bidx_nxt      = bidx_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = didx_r;
    mem_wdata     = {upd_dl, rd_iv};
    cand_ok       = 1'b0;
    cand_d        = rd_dl;

    // read issue, one entry per cycle
    if (scanning) begin
      if (cnt_r != CW'(CAPACITY)) begin
        cnt_nxt  = cnt_r + CW'(1);
        dv_nxt   = 1'b1;
        didx_nxt = cnt_r[IW-1:0];
      end else begin
        dv_nxt = 1'b0;
      end
    end

    // data stage: pick the candidate of this entry
    if (dv_r) begin
      unique case (state_r)
        S_ADD: begin
          cand_ok = valid_r[didx_r];
        end
        S_FIRE: begin
          cand_ok = valid_r[didx_r] && !taken_r[didx_r] && (rd_dl <= tv_r);
        end
        S_UPD: begin
          if (taken_r[didx_r]) begin
            if (rd_iv == '0) begin
              valid_nxt[didx_r] = 1'b0;
            end else begin
              mem_we  = 1'b1;
              cand_ok = 1'b1;
              cand_d  = upd_dl;
            end
          end else begin
            cand_ok = valid_r[didx_r];
          end
        end
        default: begin
          cand_ok = 1'b0;
        end
      endcase
    end

    // running minimum, lowest slot wins ties
    if (cand_ok && (!found_r || (cand_d < best_r))) begin
      found_nxt = 1'b1;
      best_nxt  = cand_d;
      bidx_nxt  = didx_r;
    end

    // output register drains
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          slot_nxt  = in_tdata[SLOT_W-1:0];
          tv_nxt    = TIME_BITS'(in_tdata[SLOT_W+TV_W-1:SLOT_W]);
          iv_nxt    = in_tdata[SLOT_W+TV_W+IV_W-1:SLOT_W+TV_W];
          cnt_nxt   = '0;
          dv_nxt    = 1'b0;
          found_nxt = 1'b0;
          pend_nxt  = '0;
          pend_nxt.kind = KIND_STATUS;
          pend_nxt.last = 1'b1;
          ret_nxt   = S_IDLE;
          unique case (in_tuser)
            REQ_ADD: begin
              if (!slot_in_range || valid_r[in_idx]) begin
                pend_nxt.status = ST_BUSY;
                state_nxt       = S_PUSH;
              end else begin
                state_nxt = S_ADD;
              end
            end
            REQ_DEL: begin
              if (slot_in_range && valid_r[in_idx]) begin
                valid_nxt[in_idx] = 1'b0;
                pend_nxt.status   = ST_OK;
              end else begin
                pend_nxt.status = ST_NOTFOUND;
              end
              state_nxt = S_PUSH;
            end
            REQ_EXP: begin
              taken_nxt  = '0;
              nfired_nxt = '0;
              state_nxt  = S_FIRE;
            end
            REQ_NONE: begin
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ADD: begin
        if (scan_done) begin
          mem_we            = 1'b1;
          mem_waddr         = IW'(slot_r);
          mem_wdata         = {tv_r, iv_r};
          valid_nxt[IW'(slot_r)] = 1'b1;
          pend_nxt          = '0;
          pend_nxt.kind     = KIND_STATUS;
          pend_nxt.status   = ST_OK;
          pend_nxt.earliest = !found_r || (tv_r < best_r);
          pend_nxt.last     = 1'b1;
          ret_nxt           = S_IDLE;
          state_nxt         = S_PUSH;
        end
      end

      S_FIRE: begin
        if (scan_done) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          if (found_r) begin
            taken_nxt[bidx_r] = 1'b1;
            nfired_nxt        = nfired_r + FW'(1);
            pend_nxt          = '0;
            pend_nxt.kind     = KIND_FIRED;
            pend_nxt.slot     = SLOT_W'(bidx_r);
            pend_nxt.last     = 1'b0;
            ret_nxt   = (nfired_r == FW'(MAX_FIRED - 1)) ? S_UPD : S_FIRE;
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end

      S_UPD: begin
        if (scan_done) begin
          pend_nxt          = '0;
          pend_nxt.kind     = KIND_REPORT;
          pend_nxt.deadline = found_r ? TV_W'(best_r) : '0;
          pend_nxt.empty    = !found_r;
          pend_nxt.last     = 1'b1;
          ret_nxt           = S_IDLE;
          state_nxt         = S_PUSH;
        end
      end

      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      valid_r     <= '0;
      taken_r     <= '0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      nfired_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      valid_r     <= valid_nxt;
      taken_r     <= taken_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      nfired_r    <= nfired_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    tv_r   <= tv_nxt;
    iv_r   <= iv_nxt;
    didx_r <= didx_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.empty, out_r.deadline, out_r.earliest, out_r.slot, out_r.status};

endmodule

FILE: design/tdq_ram.sv
module tdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= mem_r[rd_addr];
  end

  assign rd_data = rdata_r;

endmodule

FILE: design/tdq_checker.sv
module tdq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  // timer_slot [3:0], time_value [51:4], repeat_interval [83:52], zero fill [87:84]
  input logic [tdq_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type [1:0]
  input logic [tdq_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  // status_code [1:0], fired_slot [5:2], became_earliest [6], next_deadline [54:7],
  // queue_empty [55]
  input logic [tdq_pkg::OUT_DATA_W-1:0] out_tdata,
  // result_kind [1:0]
  input logic [tdq_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tlast
);

  import tdq_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result item changed while stalled");

  // a real request takes the block out of its waiting state
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != REQ_NONE) |=> !in_tready)
    else $error("ready held after a request was taken");

  // while waiting for a request, any pending result closes its request
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("ready for input with a request still open");

  // a fired timer is never the closing result
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FIRED) |-> !out_tlast)
    else $error("fired item marked last");

endmodule

bind timer_deadline_queue_unit tdq_checker u_tdq_checker (.*);

FILE: test/tb_timer_deadline_queue_unit.sv
`timescale 1ns / 1ps

module tb_timer_deadline_queue_unit;
  import tdq_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam logic [TV_W-1:0] TIME_MAX = {TV_W{1'b1}};
  localparam logic [IV_W-1:0] PERIOD_MAX = {IV_W{1'b1}};
  localparam int RANDOM_ITEMS = 80;
  localparam int STEADY_ITEMS = 20;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int FILL_W = IN_DATA_W - SLOT_W - TV_W - IV_W;

  // one row of the directed table
  typedef struct {
    logic [1:0]        req;
    logic [SLOT_W-1:0] slot;
    logic [TV_W-1:0]   tv;
    logic [IV_W-1:0]   iv;
    bit                typed;
    res_t              want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  // timer table as the testbench sees it
  bit                timer_live [NUM_SLOTS];
  logic [TV_W-1:0]   timer_deadline [NUM_SLOTS];
  logic [IV_W-1:0]   timer_period [NUM_SLOTS];

  res_t      step_results [$];
  res_t      pending_results [$];
  stim_row_t directed_rows [$];

  int              fault_count = 0;
  int              idle_cycles = 0;
  int              accepted_requests = 0;
  bit              steady = 1'b0;
  bit              hold_output = 1'b0;
  logic [TV_W-1:0] time_base = TV_W'(20000);

  timer_deadline_queue_unit #(
    .CAPACITY  (NUM_SLOTS),
    .TIME_BITS (TV_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic res_t make_result(logic [1:0] kind, logic [1:0] status,
                                       logic [SLOT_W-1:0] slot, logic earliest,
                                       logic [TV_W-1:0] deadline, logic empty,
                                       logic last);
    res_t r;
    r.kind     = kind;
    r.status   = status;
    r.slot     = slot;
    r.earliest = earliest;
    r.deadline = deadline;
    r.empty    = empty;
    r.last     = last;
    return r;
  endfunction

  function automatic stim_row_t row(logic [1:0] req, logic [SLOT_W-1:0] slot,
                                    logic [TV_W-1:0] tv, logic [IV_W-1:0] iv);
    stim_row_t r;
    r.req   = req;
    r.slot  = slot;
    r.tv    = tv;
    r.iv    = iv;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] req, logic [SLOT_W-1:0] slot,
                                          logic [TV_W-1:0] tv, logic [IV_W-1:0] iv,
                                          res_t want);
    stim_row_t r;
    r       = row(req, slot, tv, iv);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // earliest live deadline, 0 when the table is empty
  function automatic bit earliest_deadline(output logic [TV_W-1:0] when);
    bit found;
    found = 1'b0;
    when  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (timer_live[i] && (!found || timer_deadline[i] < when)) begin
        when  = timer_deadline[i];
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // results of one request and the table update it makes
  function automatic void predict_request(logic [1:0] req, logic [SLOT_W-1:0] slot,
                                          logic [TV_W-1:0] now_ticks,
                                          logic [IV_W-1:0] period);
    logic [TV_W-1:0] first;
    logic [TV_W:0]   rearm;
    bit              any;
    bit              picked [NUM_SLOTS];
    int              fire_order [$];
    int              pick;
    int              s;
    step_results.delete();
    case (req)
      REQ_ADD: begin
        if (timer_live[slot]) begin
          step_results.push_back(make_result(KIND_STATUS, ST_BUSY, '0, 1'b0, '0, 1'b0, 1'b1));
        end else begin
          any = earliest_deadline(first);
          timer_live[slot]     = 1'b1;
          timer_deadline[slot] = now_ticks;
          timer_period[slot]   = period;
          step_results.push_back(make_result(KIND_STATUS, ST_OK, '0,
                                             !any || now_ticks < first, '0, 1'b0, 1'b1));
        end
      end
      REQ_DEL: begin
        if (!timer_live[slot]) begin
          step_results.push_back(make_result(KIND_STATUS, ST_NOTFOUND, '0, 1'b0, '0, 1'b0,
                                             1'b1));
        end else begin
          timer_live[slot] = 1'b0;
          step_results.push_back(make_result(KIND_STATUS, ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
        end
      end
      REQ_EXP: begin
        foreach (picked[i]) picked[i] = 1'b0;
        // due timers by deadline, ties to the lower slot
        while (fire_order.size() < MAX_FIRED) begin
          pick = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (timer_live[i] && !picked[i] && timer_deadline[i] <= now_ticks &&
                (pick < 0 || timer_deadline[i] < timer_deadline[pick]))
              pick = i;
          end
          if (pick < 0) break;
          picked[pick] = 1'b1;
          fire_order.push_back(pick);
        end
        foreach (fire_order[n])
          step_results.push_back(make_result(KIND_FIRED, ST_OK, SLOT_W'(fire_order[n]),
                                             1'b0, '0, 1'b0, 1'b0));
        // free one-shots, re-arm the rest with saturation
        foreach (fire_order[n]) begin
          s = fire_order[n];
          if (timer_period[s] == '0) begin
            timer_live[s] = 1'b0;
          end else begin
            rearm = {1'b0, now_ticks} + (TV_W + 1)'(timer_period[s]);
            timer_deadline[s] = rearm[TV_W] ? TIME_MAX : rearm[TV_W-1:0];
          end
        end
        any = earliest_deadline(first);
        step_results.push_back(make_result(KIND_REPORT, ST_OK, '0, 1'b0, any ? first : '0,
                                           !any, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // offer one item, record its expected results once taken
  task automatic send_item(input logic [1:0] req, input logic [SLOT_W-1:0] slot,
                           input logic [TV_W-1:0] tv, input logic [IV_W-1:0] iv,
                           input bit typed = 1'b0, input res_t want = '0);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{FILL_W{1'b0}}, iv, tv, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(req, slot, tv, iv);
    if (req != REQ_NONE) accepted_requests++;
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[n]) pending_results.push_back(step_results[n]);
    end
    @(negedge clk);
  endtask

  // sender pause until every expected item is back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // arm every free slot near the time base, then expire them together
  task automatic fill_and_flush();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!timer_live[s])
        send_item(REQ_ADD, SLOT_W'(s), time_base + TV_W'($urandom_range(0, 7)),
                  ($urandom_range(0, 1) == 0) ? IV_W'(0) : IV_W'($urandom_range(1, 40)));
    end
    time_base = time_base + TV_W'(8);
    send_item(REQ_EXP, SLOT_W'($urandom_range(0, 15)), time_base, IV_W'($urandom));
  endtask

  // receiver: random stalls, one long hold on request
  initial begin : receiver
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = make_result(out_tuser, out_tdata[1:0], out_tdata[5:2], out_tdata[6],
                        out_tdata[54:7], out_tdata[55], out_tlast);
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("%0t unexpected item: kind %0d status %0d slot %0d deadline %0h last %0d",
                   $time, got.kind, got.status, got.slot, got.deadline, got.last);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.slot !== want.slot || got.earliest !== want.earliest ||
            got.deadline !== want.deadline || got.empty !== want.empty ||
            got.last !== want.last) begin
          if (fault_count < 10)
            $display({"%0t mismatch exp/act: kind %0d/%0d status %0d/%0d slot %0d/%0d ",
                      "earliest %0d/%0d deadline %0h/%0h empty %0d/%0d last %0d/%0d"},
                     $time, want.kind, got.kind, want.status, got.status, want.slot,
                     got.slot, want.earliest, got.earliest, want.deadline, got.deadline,
                     want.empty, got.empty, want.last, got.last);
          fault_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int              random_start;
    int              choice;
    int              live_slots [$];
    logic [1:0]      req;
    logic [SLOT_W-1:0] slot;
    logic [TV_W-1:0] tv;
    logic [IV_W-1:0] iv;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_NONE;
    foreach (timer_live[i]) timer_live[i] = 1'b0;

    // directed table: empty table, busy and missing slots, ties, extremes, saturation
    directed_rows.push_back(typed_row(REQ_EXP, 4'd0, '0, '0,
                            make_result(KIND_REPORT, ST_OK, '0, 1'b0, '0, 1'b1, 1'b1)));
    directed_rows.push_back(typed_row(REQ_DEL, 4'd0, '0, '0,
                            make_result(KIND_STATUS, ST_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b1)));
    directed_rows.push_back(typed_row(REQ_ADD, 4'd0, TV_W'(1000), '0,
                            make_result(KIND_STATUS, ST_OK, '0, 1'b1, '0, 1'b0, 1'b1)));
    directed_rows.push_back(typed_row(REQ_ADD, 4'd0, TV_W'(5), IV_W'(3),
                            make_result(KIND_STATUS, ST_BUSY, '0, 1'b0, '0, 1'b0, 1'b1)));
    directed_rows.push_back(typed_row(REQ_ADD, 4'd15, TIME_MAX, PERIOD_MAX,
                            make_result(KIND_STATUS, ST_OK, '0, 1'b0, '0, 1'b0, 1'b1)));
    directed_rows.push_back(row(REQ_ADD, 4'd7, TV_W'(1000), IV_W'(5)));
    directed_rows.push_back(typed_row(REQ_ADD, 4'd3, '0, IV_W'(1),
                            make_result(KIND_STATUS, ST_OK, '0, 1'b1, '0, 1'b0, 1'b1)));
    directed_rows.push_back(row(REQ_NONE, 4'd5, TIME_MAX, PERIOD_MAX));
    directed_rows.push_back(row(REQ_EXP, 4'd0, TV_W'(999), '0));
    directed_rows.push_back(row(REQ_EXP, 4'd0, TV_W'(1000), '0));
    directed_rows.push_back(row(REQ_DEL, 4'd0, '0, '0));
    directed_rows.push_back(row(REQ_DEL, 4'd7, '0, '0));
    directed_rows.push_back(row(REQ_ADD, 4'd1, TIME_MAX - TV_W'(2), IV_W'(100)));
    directed_rows.push_back(row(REQ_EXP, 4'd9, TIME_MAX - TV_W'(1), PERIOD_MAX));
    directed_rows.push_back(row(REQ_EXP, 4'd15, TIME_MAX, PERIOD_MAX));
    directed_rows.push_back(row(REQ_DEL, 4'd1, '0, '0));
    directed_rows.push_back(row(REQ_DEL, 4'd3, '0, '0));
    directed_rows.push_back(row(REQ_DEL, 4'd15, TIME_MAX, PERIOD_MAX));
    directed_rows.push_back(typed_row(REQ_EXP, 4'd0, '0, '0,
                            make_result(KIND_REPORT, ST_OK, '0, 1'b0, '0, 1'b1, 1'b1)));
    directed_rows.push_back(row(REQ_ADD, 4'd2, '0, '0));
    directed_rows.push_back(row(REQ_EXP, 4'd0, TIME_MAX, '0));

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].req, directed_rows[r].slot, directed_rows[r].tv,
                directed_rows[r].iv, directed_rows[r].typed, directed_rows[r].want);
    wait_results_drained();

    // full table under a long output hold
    random_start = accepted_requests;
    hold_output  = 1'b1;
    fill_and_flush();

    // random mix of well-formed traffic and noise
    while (accepted_requests - random_start < RANDOM_ITEMS) begin
      if (!steady && accepted_requests - random_start >= RANDOM_ITEMS - STEADY_ITEMS) begin
        wait_results_drained();
        steady = 1'b1;
      end
      choice = $urandom_range(0, 15);
      if (choice == 0) begin
        fill_and_flush();
      end else begin
        tv   = TV_W'({$urandom, $urandom});
        iv   = IV_W'($urandom);
        slot = SLOT_W'($urandom_range(0, 15));
        if (choice <= 2) begin
          req = 2'($urandom_range(0, 3));
        end else if (choice <= 8) begin
          req = REQ_ADD;
          tv  = time_base + TV_W'($urandom_range(0, 300));
          iv  = ($urandom_range(0, 2) == 0) ? IV_W'(0) : IV_W'($urandom_range(1, 200));
        end else if (choice <= 11) begin
          req = REQ_DEL;
          live_slots.delete();
          foreach (timer_live[i]) if (timer_live[i]) live_slots.push_back(i);
          if (live_slots.size() != 0 && $urandom_range(0, 4) != 0)
            slot = SLOT_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
        end else begin
          req       = REQ_EXP;
          time_base = time_base + TV_W'($urandom_range(0, 120));
          tv        = time_base;
        end
        send_item(req, slot, tv, iv);
      end
    end
    in_tvalid <= 1'b0;

    // wait for the tail of results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tdq_pkg.sv
design/tdq_ram.sv
design/timer_deadline_queue_unit.sv
design/tdq_checker.sv
test/tb_timer_deadline_queue_unit.sv
